// ===== rtl/core/polar_touch_cell_mapper_defines.svh =====
// Assertion macros for the polar touch cell mapper.
// No dependencies; include from any module that asserts.
`ifndef POLAR_TOUCH_CELL_MAPPER_DEFINES_SVH
`define POLAR_TOUCH_CELL_MAPPER_DEFINES_SVH

// same-cycle implication, masked during reset
`define PTCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define PTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ptcm_pkg.sv =====
// Shared types and constants of the polar touch cell mapper.
// No dependencies.
package ptcm_pkg;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } t_point;

    typedef struct packed {
        logic       hit;
        logic [7:0] cell_index;
    } t_result;

    typedef enum logic [2:0] {
        CFG_CENTER_X        = 3'd0,
        CFG_CENTER_Y        = 3'd1,
        CFG_OUTER_RADIUS    = 3'd2,
        CFG_INNER_RADIUS    = 3'd3,
        CFG_START_ANGLE     = 3'd4,
        CFG_ANGLE_SPAN      = 3'd5,
        CFG_FORCE_SIDE_ONE  = 3'd6,
        CFG_REVERSE_SECTORS = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W    = 18;
    localparam int CORDIC_STEPS  = 16;
    localparam int COORD_FRAC    = 14;
    localparam logic [7:0]  CELL_MAX     = 8'd239;
    localparam logic [31:0] ANGLE_ROUND  = 32'h0000_8000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

endpackage

// ===== rtl/core/polar_touch_cell_mapper.sv =====
// Polar touch cell mapper: a pipeline from input beat to result beat, one beat per cycle
// sustained while the receiver does not hold back results; the 16 CORDIC stages and
// the one-bit-per-stage sector divider set the depth. All stages stall together.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on ptcm_pkg and polar_touch_cell_mapper_defines.svh.
`include "polar_touch_cell_mapper_defines.svh"

module polar_touch_cell_mapper #(
    parameter int SECTORS = 24,
    parameter int RINGS   = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ptcm_pkg::t_point             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ptcm_pkg::t_result            o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [2:0]                   i_cfg_index,
    input  logic [ptcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ptcm_pkg::*;

    localparam int QW     = $clog2(SECTORS);
    localparam int RGW    = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int TW     = 16 + $clog2(RINGS + 1);
    localparam int SQW    = 2 * TW;
    localparam int LW     = 34 + 2 * $clog2(RINGS + 1);
    localparam int DW     = 18 + QW + 1;
    localparam int CXW    = 35;
    localparam int CLW0   = $clog2(2 * RINGS * SECTORS);
    localparam int CLW    = (CLW0 > 8) ? CLW0 : 8;
    localparam int S_CAP  = 0;
    localparam int S_SQ   = 1;
    localparam int S_CRD0 = 2;
    localparam int S_SUM  = 2;
    localparam int S_RNG  = 3;
    localparam int S_RING = 4;
    localparam int S_ANG  = S_CRD0 + CORDIC_STEPS;
    localparam int S_DIV0 = S_ANG + 1;
    localparam int NST    = S_DIV0 + QW;

    typedef struct packed {
        logic signed [16:0]     dx;
        logic signed [16:0]     dy;
        logic [32:0]            dxx;
        logic [32:0]            dyy;
        logic [33:0]            d2;
        logic [LW-1:0]          lhs;
        logic                   inr;
        logic                   side;
        logic                   zero;
        logic [RGW-1:0]         ring;
        logic signed [CXW-1:0]  cx;
        logic signed [CXW-1:0]  cy;
        logic [31:0]            cz;
        logic                   hit;
        logic [DW-1:0]          rem;
        logic [QW-1:0]          q;
    } t_stage;

    logic signed [15:0]     r_center_x;
    logic signed [15:0]     r_center_y;
    logic [15:0]            r_outer_radius;
    logic [15:0]            r_inner_radius;
    logic [15:0]            r_start_angle;
    logic [17:0]            r_angle_span;
    logic                   r_force_side_one;
    logic                   r_reverse_sectors;

    logic [31:0]            r_osq;
    logic [31:0]            r_isq;
    logic                   r_eq;
    logic [TW-1:0]          r_t   [RINGS];
    logic [SQW-1:0]         r_tsq [RINGS];

    logic [NST-1:0]         r_vld;
    t_stage                 r_stg [NST];
    t_stage                 n_stg [NST];
    logic                   r_out_vld;
    t_result                r_out;
    t_result                n_out;
    logic                   adv;

    assign adv         = !r_out_vld || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x        <= 16'sd8192;
            r_center_y        <= 16'sd8192;
            r_outer_radius    <= 16'd8192;
            r_inner_radius    <= 16'd0;
            r_start_angle     <= 16'd0;
            r_angle_span      <= 18'd65536;
            r_force_side_one  <= 1'b0;
            r_reverse_sectors <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X:        r_center_x        <= i_cfg_data[15:0];
                CFG_CENTER_Y:        r_center_y        <= i_cfg_data[15:0];
                CFG_OUTER_RADIUS:    r_outer_radius    <= i_cfg_data[15:0];
                CFG_INNER_RADIUS:    r_inner_radius    <= i_cfg_data[15:0];
                CFG_START_ANGLE:     r_start_angle     <= i_cfg_data[15:0];
                CFG_ANGLE_SPAN:      r_angle_span      <= i_cfg_data[17:0];
                CFG_FORCE_SIDE_ONE:  r_force_side_one  <= i_cfg_data[0];
                CFG_REVERSE_SECTORS: r_reverse_sectors <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ring thresholds are registered from the radii, r_t first and r_tsq after it
    always_ff @(posedge i_clk) begin
        r_osq <= 32'(r_outer_radius) * 32'(r_outer_radius);
        r_isq <= 32'(r_inner_radius) * 32'(r_inner_radius);
        r_eq  <= (r_outer_radius == r_inner_radius);
        for (int k = 0; k < RINGS; k++) begin
            r_t[k]   <= TW'(TW'(RINGS) * TW'(r_inner_radius)
                        + TW'(k) * TW'(r_outer_radius - r_inner_radius));
            r_tsq[k] <= SQW'(r_t[k]) * SQW'(r_t[k]);
        end
    end

    always_comb begin
        t_stage             st;
        logic signed [33:0] sq_x;
        logic signed [33:0] sq_y;
        logic signed [CXW-1:0] ex;
        logic signed [CXW-1:0] ey;
        logic [15:0]        ang;
        logic [15:0]        rel;
        logic [DW-1:0]      dv;
        int                 ci;
        int                 db;
        for (int s = 0; s < NST; s++) begin
            st = (s == 0) ? '0 : r_stg[(s == 0) ? 0 : s - 1];
            if (s == S_CAP) begin
                st.dx   = 17'(i_in_data.point_x) - 17'(r_center_x);
                st.dy   = 17'(i_in_data.point_y) - 17'(r_center_y);
                st.side = r_force_side_one || (i_in_data.point_x < r_center_x);
            end
            if (s == S_SQ) begin
                sq_x    = 34'(st.dx) * 34'(st.dx);
                sq_y    = 34'(st.dy) * 34'(st.dy);
                st.dxx  = sq_x[32:0];
                st.dyy  = sq_y[32:0];
                st.zero = (st.dx == '0) && (st.dy == '0);
                ex      = CXW'(st.dx) <<< COORD_FRAC;
                ey      = CXW'(st.dy) <<< COORD_FRAC;
                if (st.dx < 0) begin
                    st.cx = -ex;
                    st.cy = -ey;
                    st.cz = HALF_TURN;
                end else begin
                    st.cx = ex;
                    st.cy = ey;
                    st.cz = '0;
                end
            end
            if (s == S_SUM) begin
                st.d2 = {1'b0, st.dxx} + {1'b0, st.dyy};
            end
            if (s == S_RNG) begin
                st.inr = (st.d2 <= {2'b0, r_osq}) && (st.d2 >= {2'b0, r_isq});
                st.lhs = LW'(st.d2) * LW'(RINGS * RINGS);
            end
            if (s == S_RING) begin
                st.ring = '0;
                for (int k = 0; k < RINGS; k++) begin
                    if (LW'(r_tsq[k]) <= st.lhs) begin
                        st.ring = RGW'(k);
                    end
                end
                if (r_eq) begin
                    st.ring = '0;
                end
            end
            if (s >= S_CRD0 && s < S_ANG) begin
                ci = s - S_CRD0;
                ex = st.cx;
                ey = st.cy;
                if (ey >= 0) begin
                    st.cx = ex + (ey >>> ci);
                    st.cy = ey - (ex >>> ci);
                    st.cz = st.cz + ATAN_TURNS[ci];
                end else begin
                    st.cx = ex - (ey >>> ci);
                    st.cy = ey + (ex >>> ci);
                    st.cz = st.cz - ATAN_TURNS[ci];
                end
            end
            if (s == S_ANG) begin
                ang    = st.zero ? 16'd0 : 16'((st.cz + ANGLE_ROUND) >> 16);
                rel    = ang - r_start_angle;
                st.hit = st.inr && ({2'b0, rel} < r_angle_span);
                st.rem = DW'(rel) * DW'(SECTORS);
                st.q   = '0;
            end
            if (s >= S_DIV0) begin
                db = QW - 1 - (s - S_DIV0);
                dv = DW'(r_angle_span) << db;
                if (st.rem >= dv) begin
                    st.rem   = st.rem - dv;
                    st.q[db] = 1'b1;
                end
            end
            n_stg[s] = st;
        end
    end

    always_comb begin
        t_stage          st;
        logic [QW-1:0]   sec;
        logic [CLW-1:0]  cell_no;
        st      = r_stg[NST-1];
        sec     = r_reverse_sectors ? QW'(SECTORS - 1) - st.q : st.q;
        cell_no = (st.side ? CLW'(RINGS * SECTORS) : '0)
                + CLW'(st.ring) * CLW'(SECTORS) + CLW'(sec);
        if (cell_no > CLW'(CELL_MAX)) begin
            cell_no = CLW'(CELL_MAX);
        end
        n_out.hit        = st.hit;
        n_out.cell_index = st.hit ? cell_no[7:0] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[NST-2:0], i_in_valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NST; s++) begin
                r_stg[s] <= n_stg[s];
            end
            r_out <= n_out;
        end
    end

    `PTCM_ASSERT_NOW(a_miss_zero, o_out_valid && !o_out_data.hit,
        o_out_data.cell_index == 8'd0, "miss carries nonzero cell")
    `PTCM_ASSERT_NOW(a_cell_max, o_out_valid, o_out_data.cell_index <= CELL_MAX,
        "cell above limit")
    `PTCM_ASSERT_NOW(a_bad_band, o_out_valid && (r_inner_radius > r_outer_radius),
        !o_out_data.hit, "hit with inner radius above outer")
    `PTCM_ASSERT_NEXT(a_enter, i_in_valid && o_in_ready, r_vld[0],
        "accepted beat lost at pipeline entry")
    `PTCM_ASSERT_NEXT(a_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(r_vld), "pipeline moved during stall")

endmodule

// ===== tb/polar_touch_cell_mapper_checker.sv =====
// Checker for polar_touch_cell_mapper: tracks register writes, predicts one result per
// accepted point and compares result beats in order. Depends on ptcm_pkg.
module polar_touch_cell_mapper_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  ptcm_pkg::t_point                i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  ptcm_pkg::t_result               i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [ptcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_fails,
    output int                              o_hits
);
    import ptcm_pkg::*;

    localparam int SECTORS = 24;
    localparam int RINGS   = 5;

    typedef struct {
        longint cx, cy, outer, inner, start, span, force_one, reverse;
    } t_grid;

    t_grid   grid;
    t_result cell_q[$];

    function automatic logic [15:0] turn_angle(longint dx, longint dy);
        longint x, y, nx, ny;
        logic [31:0] z;
        logic [31:0] zr;
        if (dx == 0 && dy == 0) begin
            return 16'd0;
        end
        x = dx * 16384;
        y = dy * 16384;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_TURNS[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_TURNS[i];
            end
            x = nx;
            y = ny;
        end
        zr = z + ANGLE_ROUND;
        return zr[31:16];
    endfunction

    function automatic t_result map_point(t_grid g, t_point p);
        t_result r;
        longint px, py, dx, dy, d2, rel, sector, ring, side, cell_no, t;
        px = p.point_x;
        py = p.point_y;
        dx = px - g.cx;
        dy = py - g.cy;
        d2 = dx * dx + dy * dy;
        r = '0;
        if (d2 > g.outer * g.outer || d2 < g.inner * g.inner) begin
            return r;
        end
        rel = (longint'(turn_angle(dx, dy)) - g.start) & 64'hFFFF;
        if (rel >= g.span) begin
            return r;
        end
        sector = (rel * SECTORS) / g.span;
        if (g.reverse != 0) begin
            sector = SECTORS - 1 - sector;
        end
        ring = 0;
        if (g.outer != g.inner) begin
            for (int k = 1; k < RINGS; k++) begin
                t = RINGS * g.inner + k * (g.outer - g.inner);
                if (t * t <= RINGS * RINGS * d2) begin
                    ring = k;
                end
            end
        end
        side = (g.force_one != 0) ? 1 : ((px >= g.cx) ? 0 : 1);
        cell_no = side * RINGS * SECTORS + ring * SECTORS + sector;
        if (cell_no > CELL_MAX) begin
            cell_no = CELL_MAX;
        end
        r.hit        = 1'b1;
        r.cell_index = cell_no[7:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            grid      <= '{8192, 8192, 8192, 0, 0, 65536, 0, 0};
            cell_q.delete();
            o_pending <= 0;
            o_fails   <= 0;
            o_hits    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CENTER_X:        grid.cx <= longint'($signed(i_cfg_data[15:0]));
                    CFG_CENTER_Y:        grid.cy <= longint'($signed(i_cfg_data[15:0]));
                    CFG_OUTER_RADIUS:    grid.outer <= i_cfg_data[15:0];
                    CFG_INNER_RADIUS:    grid.inner <= i_cfg_data[15:0];
                    CFG_START_ANGLE:     grid.start <= i_cfg_data[15:0];
                    CFG_ANGLE_SPAN:      grid.span <= i_cfg_data;
                    CFG_FORCE_SIDE_ONE:  grid.force_one <= i_cfg_data[0];
                    CFG_REVERSE_SECTORS: grid.reverse <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                cell_q.push_back(map_point(grid, i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (cell_q.size() == 0) begin
                    $error("unexpected result beat hit=%0d cell_index=%0d",
                           i_out_data.hit, i_out_data.cell_index);
                    o_fails <= o_fails + 1;
                end else begin
                    want = cell_q.pop_front();
                    if (want.hit) begin
                        o_hits <= o_hits + 1;
                    end
                    if (want.hit !== i_out_data.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_out_data.hit);
                        o_fails <= o_fails + 1;
                    end else if (want.cell_index !== i_out_data.cell_index) begin
                        $error("cell_index: expected %0d, got %0d",
                               want.cell_index, i_out_data.cell_index);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            o_pending <= cell_q.size();
        end
    end
endmodule

// ===== tb/polar_touch_cell_mapper_test.sv =====
// Top of the polar_touch_cell_mapper testbench: drives points, register writes and
// result backpressure; polar_touch_cell_mapper_checker does the checking.
module polar_touch_cell_mapper_test;
    import ptcm_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN       = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_point                in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_result               out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending, fails, hits;
    int                    cycles = 0;
    int                    points_sent = 0;
    logic                  burst = 1'b0;
    logic                  long_hold = 1'b0;
    int                    hold_left = 0;
    longint                cfg_now[8];

    always #4 clk = ~clk;

    polar_touch_cell_mapper uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    polar_touch_cell_mapper_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_fails(fails), .o_hits(hits)
    );

    function automatic int pick_gap();
        if (burst) begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(5, 30);
    endfunction

    // receiver side: random stalls, one long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (long_hold) begin
            out_ready <= 1'b0;
            hold_left <= 300;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (burst) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            hold_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(5, 30);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("polar_touch_cell_mapper_test: FAIL");
            $finish;
        end
    end

    task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{point_x: px, point_y: py};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        points_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_now[idx] = value;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_grid(longint cx, longint cy, longint outer, longint inner,
                            longint start, longint span, longint force_one,
                            longint reverse);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_OUTER_RADIUS, outer);
        write_reg(CFG_INNER_RADIUS, inner);
        write_reg(CFG_START_ANGLE, start);
        write_reg(CFG_ANGLE_SPAN, span);
        write_reg(CFG_FORCE_SIDE_ONE, force_one);
        write_reg(CFG_REVERSE_SECTORS, reverse);
        cfg_valid <= 1'b0;
    endtask

    // mostly points near the annulus, the rest anywhere
    task automatic random_points(int count);
        longint cx, cy, reach, px, py;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                burst <= ($urandom_range(0, 2) == 0);
            end
            cx    = $signed(cfg_now[CFG_CENTER_X][15:0]);
            cy    = $signed(cfg_now[CFG_CENTER_Y][15:0]);
            reach = cfg_now[CFG_OUTER_RADIUS] + cfg_now[CFG_OUTER_RADIUS] / 8 + 2;
            if ($urandom_range(0, 4) != 0) begin
                px = cx + longint'($urandom_range(0, 2 * reach)) - reach;
                py = cy + longint'($urandom_range(0, 2 * reach)) - reach;
                px = (px > 32767) ? 32767 : ((px < -32768) ? -32768 : px);
                py = (py > 32767) ? 32767 : ((py < -32768) ? -32768 : py);
            end else begin
                px = $signed(16'($urandom()));
                py = $signed(16'($urandom()));
            end
            send_point(px[15:0], py[15:0]);
        end
        burst <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            cfg_now[i] = 0;
        end
        cfg_now[CFG_CENTER_X]     = 8192;
        cfg_now[CFG_CENTER_Y]     = 8192;
        cfg_now[CFG_OUTER_RADIUS] = 8192;
        cfg_now[CFG_ANGLE_SPAN]   = 65536;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: center, edges, each quadrant, field extremes
        send_point(16'sd8192, 16'sd8192);
        send_point(16'sd16384, 16'sd8192);
        send_point(16'sd16385, 16'sd8192);
        send_point(16'sd0, 16'sd8192);
        send_point(16'sd8192, 16'sd16384);
        send_point(16'sd8192, 16'sd0);
        send_point(16'sd12000, 16'sd4000);
        send_point(16'sd4000, 16'sd12000);
        send_point(16'sd4000, 16'sd4000);
        send_point(16'sd8193, 16'sd8192);
        send_point(16'sd8191, 16'sd8192);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, -16'sd32768);
        send_point(16'sd10000, 16'sd8191);
        drain();

        set_grid(0, 0, 8192, 8192, 0, 65536, 1, 1);
        send_point(16'sd8192, 16'sd0);
        send_point(16'sd0, -16'sd8192);
        send_point(16'sd0, 16'sd0);
        send_point(-16'sd8192, 16'sd0);
        send_point(16'sd1, 16'sd0);
        drain();

        set_grid(0, 0, 30000, 20000, 16384, 1, 0, 0);
        send_point(16'sd0, 16'sd25000);
        send_point(16'sd100, 16'sd25000);
        drain();

        // long receiver hold while points keep coming
        set_grid(0, 0, 20000, 2000, 0, 65536, 0, 0);
        long_hold <= 1'b1;
        @(posedge clk);
        long_hold <= 1'b0;
        random_points(120);
        drain();

        random_points(200);
        drain();
        set_grid(-32768, 32767, 65535, 0, 65535, 131072, 0, 1);
        random_points(200);
        drain();
        set_grid(32767, -32768, 65535, 65535, 32768, 32768, 1, 0);
        random_points(150);
        drain();
        set_grid(0, 0, 1000, 5000, 0, 65536, 0, 0);
        random_points(60);
        drain();
        set_grid(-100, 300, 9000, 3000, 49152, 24000, 0, 0);
        random_points(200);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            set_grid($signed(16'($urandom())), $signed(16'($urandom())),
                     $urandom_range(0, 65535), $urandom_range(0, 20000),
                     $urandom_range(0, 65535), $urandom_range(1, 131072),
                     $urandom_range(0, 1), $urandom_range(0, 1));
            random_points(240);
            drain();
        end

        $display("covered %0d points over 12 register settings, %0d of them hits",
                 points_sent, hits);
        if (fails == 0) begin
            $display("polar_touch_cell_mapper_test: PASS");
        end else begin
            $display("polar_touch_cell_mapper_test: FAIL");
        end
        $finish;
    end
endmodule
